[hdl/aging_thread_scheduler_core_assert.svh]
// Assertion macros for the aging thread scheduler
`ifndef AGING_THREAD_SCHEDULER_CORE_ASSERT_SVH
`define AGING_THREAD_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication
`define ATS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ats: same-cycle check failed");

// Next-cycle implication
`define ATS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ats: next-cycle check failed");

`endif

[hdl/ats_pkg.sv]
// Shared types, codes and helpers of the aging thread scheduler
package ats_pkg;

  localparam int AGE_W   = 16;
  localparam int OWNER_W = 8;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_YIELD  = 3'd1;
  localparam logic [2:0] CMD_SLEEP  = 3'd2;
  localparam logic [2:0] CMD_WAKEUP = 3'd3;
  localparam logic [2:0] CMD_CREATE = 3'd4;
  localparam logic [2:0] CMD_FREE   = 3'd5;

  localparam logic [2:0] ST_AVAILABLE = 3'd0;
  localparam logic [2:0] ST_READY     = 3'd1;
  localparam logic [2:0] ST_RUNNING   = 3'd2;
  localparam logic [2:0] ST_WAITING   = 3'd3;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_BAD_INDEX = 2'd1;
  localparam logic [1:0] STS_NO_SLOT   = 2'd2;

  localparam logic [AGE_W-1:0]   AGE_MAX        = 16'hFFFF;
  localparam logic [AGE_W-1:0]   QUANTUM_RESET  = 16'd100;
  localparam logic [OWNER_W-1:0] KERNEL_OWNER   = 8'h00;
  localparam logic [OWNER_W-1:0] FREE_OWNER     = 8'hFF;

  typedef struct packed {
    logic [2:0]         st;
    logic [AGE_W-1:0]   age;
    logic [OWNER_W-1:0] owner;
  } ats_entry_t;

  localparam ats_entry_t ENTRY_KERNEL = '{ST_RUNNING, 16'd1, KERNEL_OWNER};
  localparam ats_entry_t ENTRY_BLANK  = '{ST_AVAILABLE, 16'd0, FREE_OWNER};
  localparam ats_entry_t ENTRY_FREED  = '{ST_AVAILABLE, AGE_MAX, FREE_OWNER};

  typedef struct packed {
    logic [3:0] running_thread;
    logic       switched;
    logic [1:0] status;
    logic [3:0] created_thread;
  } ats_result_t;

  function automatic logic [AGE_W-1:0] sat_inc(input logic [AGE_W-1:0] v);
    sat_inc = (v == AGE_MAX) ? v : v + 16'd1;
  endfunction

endpackage

[hdl/ats_table.sv]
// Thread table memory with per-entry written bits and registered read
module ats_table import ats_pkg::*; #(
  parameter int SLOTS  = 16,
  parameter int ADDR_W = $clog2(SLOTS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output ats_entry_t        rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  ats_entry_t        wr_data
);

  ats_entry_t       mem [SLOTS];
  logic [SLOTS-1:0] written;
  ats_entry_t       rd_raw;
  logic             rd_hit;
  logic             rd_kernel;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw    <= mem[rd_addr];
      rd_hit    <= written[rd_addr];
      rd_kernel <= (rd_addr == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_hit ? rd_raw : (rd_kernel ? ENTRY_KERNEL : ENTRY_BLANK);

endmodule

[hdl/ats_seq.sv]
// Command sequencer: decode, table scans, selection pass and table updates
module ats_seq import ats_pkg::*; #(
  parameter int SLOTS  = 16,
  parameter int ADDR_W = $clog2(SLOTS),
  parameter int CNT_W  = $clog2(SLOTS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       quantum_limit,
  input  logic              in_take,
  input  logic [2:0]        command,
  input  logic [3:0]        target_thread,
  input  logic [7:0]        owner_id,
  output logic              busy,
  output logic              res_valid,
  input  logic              res_take,
  output ats_result_t       res,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  input  ats_entry_t        rd_data,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output ats_entry_t        wr_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_PRE    = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_PICK   = 3'd4;
  localparam logic [2:0] S_CREATE = 3'd5;
  localparam logic [2:0] S_WAKE   = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0]         state;
  logic [2:0]         cmd_q;
  logic [3:0]         tid_q;
  logic [7:0]         owner_q;
  logic [ADDR_W-1:0]  cur;
  logic [15:0]        qc;
  logic [CNT_W-1:0]   cnt;
  logic               proc_valid;
  logic [ADDR_W-1:0]  proc_idx;
  logic [ADDR_W-1:0]  pick;
  logic [AGE_W-1:0]   pick_age;
  logic [OWNER_W-1:0] pick_owner;
  logic               switched_q;
  logic [1:0]         status_q;
  logic [ADDR_W-1:0]  created_q;

  logic [ADDR_W+3:0]  tid_wide;
  logic [ADDR_W-1:0]  tid_idx;
  logic               tid_ok;
  logic               issue;
  logic               entry_ready;
  logic [AGE_W-1:0]   new_age;
  logic               slot_found;
  logic               pass_due;
  logic [2:0]         pre_st;
  logic [ADDR_W+3:0]  cur_wide;
  logic [ADDR_W+3:0]  created_wide;

  assign tid_wide    = {ADDR_W'(0), tid_q};
  assign tid_idx     = tid_wide[ADDR_W-1:0];
  assign tid_ok      = (tid_q != 4'd0) && (tid_wide < (ADDR_W + 4)'(SLOTS));
  assign issue       = (cnt != CNT_W'(SLOTS));
  assign entry_ready = (rd_data.st == ST_READY);
  assign new_age     = entry_ready ? sat_inc(rd_data.age) : rd_data.age;
  assign slot_found  = proc_valid && (rd_data.st == ST_AVAILABLE);
  assign pass_due    = (qc >= quantum_limit);
  assign pre_st      = (cmd_q == CMD_SLEEP) ? ST_WAITING :
                       ((rd_data.st == ST_RUNNING) ? ST_READY : rd_data.st);

  assign busy      = (state != S_IDLE);
  assign res_valid = (state == S_FINISH);

  assign cur_wide     = {4'd0, cur};
  assign created_wide = {4'd0, created_q};
  assign res = '{cur_wide[3:0], switched_q, status_q, created_wide[3:0]};

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt[ADDR_W-1:0];
    wr_en   = 1'b0;
    wr_addr = proc_idx;
    wr_data = rd_data;
    unique case (state)
      S_DECODE: begin
        unique case (cmd_q)
          CMD_TICK: begin
            rd_en   = pass_due;
            rd_addr = cur;
          end
          CMD_YIELD, CMD_SLEEP: begin
            rd_en   = 1'b1;
            rd_addr = cur;
          end
          CMD_WAKEUP: begin
            rd_en   = tid_ok;
            rd_addr = tid_idx;
          end
          CMD_FREE: begin
            wr_en   = tid_ok;
            wr_addr = tid_idx;
            wr_data = ENTRY_FREED;
          end
          default: ;
        endcase
      end
      S_PRE: begin
        wr_en      = 1'b1;
        wr_addr    = cur;
        wr_data.st = pre_st;
      end
      S_SCAN: begin
        rd_en       = issue;
        wr_en       = proc_valid && entry_ready;
        wr_data.age = new_age;
      end
      S_PICK: begin
        wr_en   = 1'b1;
        wr_addr = pick;
        wr_data = '{ST_RUNNING, AGE_W'(0), pick_owner};
      end
      S_CREATE: begin
        rd_en   = issue && !slot_found;
        wr_en   = slot_found;
        wr_data = '{ST_READY, 16'd1, owner_q};
      end
      S_WAKE: begin
        wr_en      = 1'b1;
        wr_addr    = tid_idx;
        wr_data.st = ST_READY;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur   <= '0;
      qc    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            cmd_q   <= command;
            tid_q   <= target_thread;
            owner_q <= owner_id;
            state   <= S_DECODE;
          end
        end
        S_DECODE: begin
          status_q   <= (((cmd_q == CMD_WAKEUP) || (cmd_q == CMD_FREE)) && !tid_ok) ?
                        STS_BAD_INDEX : STS_OK;
          switched_q <= 1'b0;
          created_q  <= '0;
          cnt        <= '0;
          proc_valid <= 1'b0;
          unique case (cmd_q)
            CMD_TICK: begin
              qc    <= sat_inc(qc);
              state <= pass_due ? S_PRE : S_FINISH;
            end
            CMD_YIELD, CMD_SLEEP: begin
              state <= S_PRE;
            end
            CMD_WAKEUP: begin
              state <= tid_ok ? S_WAKE : S_FINISH;
            end
            CMD_CREATE: begin
              state <= S_CREATE;
            end
            CMD_FREE: begin
              state <= S_FINISH;
            end
            default: begin
              state <= S_FINISH;
            end
          endcase
        end
        S_PRE: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (issue) begin
            cnt <= cnt + CNT_W'(1);
          end
          proc_valid <= issue;
          proc_idx   <= cnt[ADDR_W-1:0];
          if (proc_valid) begin
            priority if (proc_idx == '0) begin
              pick       <= '0;
              pick_age   <= new_age;
              pick_owner <= rd_data.owner;
            end else if (entry_ready && (rd_data.age >= pick_age)) begin
              pick       <= proc_idx;
              pick_age   <= new_age;
              pick_owner <= rd_data.owner;
            end else begin
              // hold the pick
            end
            if (!issue) begin
              state <= S_PICK;
            end
          end
        end
        S_PICK: begin
          cur        <= pick;
          qc         <= '0;
          switched_q <= 1'b1;
          state      <= S_FINISH;
        end
        S_CREATE: begin
          if (issue) begin
            cnt <= cnt + CNT_W'(1);
          end
          proc_valid <= issue;
          proc_idx   <= cnt[ADDR_W-1:0];
          priority if (slot_found) begin
            created_q <= proc_idx;
            state     <= S_FINISH;
          end else if (proc_valid && !issue) begin
            status_q <= STS_NO_SLOT;
            state    <= S_FINISH;
          end else begin
            // advance the scan
          end
        end
        S_WAKE: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/aging_thread_scheduler_core.sv]
// Aging thread scheduler: top level with limit register and result register
// Tick without preemption, free, rejected wakeup and unused codes go from decode straight to
// the result; wakeup adds a table write; a selection pass adds a write of the old thread, a
// scan of the table and a write of the pick; create scans until it finds a free slot or the
// table ends. One item at a time; the single read port of the table scans one entry per cycle.
// Reset (synchronous): thread 0 running, table written bits cleared at once, limit 100.
module aging_thread_scheduler_core import ats_pkg::*; #(
  parameter int THREAD_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] quantum_limit,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [3:0]  target_thread,
  input  logic [7:0]  owner_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  running_thread,
  output logic        switched,
  output logic [1:0]  status,
  output logic [3:0]  created_thread
);

  localparam int ADDR_W = $clog2(THREAD_SLOTS);

  logic [15:0]       limit;
  logic              busy;
  logic              res_valid;
  logic              res_take;
  ats_result_t       res;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  ats_entry_t        rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  ats_entry_t        wr_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign res_take  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= QUANTUM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= quantum_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      running_thread <= res.running_thread;
      switched       <= res.switched;
      status         <= res.status;
      created_thread <= res.created_thread;
    end
  end

  ats_seq #(
    .SLOTS  (THREAD_SLOTS),
    .ADDR_W (ADDR_W)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .quantum_limit (limit),
    .in_take       (in_valid && !in_stall),
    .command       (command),
    .target_thread (target_thread),
    .owner_id      (owner_id),
    .busy          (busy),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res           (res),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

  ats_table #(
    .SLOTS  (THREAD_SLOTS),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

[hdl/ats_checker.sv]
// Port-level checks of the aging thread scheduler and their binding
`include "aging_thread_scheduler_core_assert.svh"

module ats_checker import ats_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] running_thread,
  input logic       switched,
  input logic [1:0] status,
  input logic [3:0] created_thread
);

  `ATS_ASSERT_NOW(a_status_code, clk, rst, out_valid, (status == STS_OK) || (status == STS_BAD_INDEX) || (status == STS_NO_SLOT))
  `ATS_ASSERT_NOW(a_switch_clean, clk, rst, out_valid && switched, (status == STS_OK) && (created_thread == 4'd0))
  `ATS_ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && !in_stall, in_stall)
  `ATS_ASSERT_NEXT(a_result_held, clk, rst, out_valid && out_stall, out_valid && $stable(running_thread) && $stable(status))

endmodule

bind aging_thread_scheduler_core ats_checker u_ats_checker (.*);

[dv/tb.sv]
// Self-checking testbench for the aging thread scheduler core
module tb;
  import ats_pkg::*;

  localparam int SLOTS       = 16;
  localparam int TAIL_CYCLES = SLOTS + 8;
  localparam int CYCLE_LIMIT = 300000;

  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  localparam logic [3:0] KERNEL_IDX  = 4'd0;

  localparam int MODE_MIXED   = 0;
  localparam int MODE_TICKS   = 1;
  localparam int MODE_CREATES = 2;

  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] tid;
    logic [7:0] owner;
  } sched_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] quantum_limit = QUANTUM_RESET;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  command = CMD_TICK;
  logic [3:0]  target_thread = 4'd0;
  logic [7:0]  owner_id = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  running_thread;
  logic        switched;
  logic [1:0]  status;
  logic [3:0]  created_thread;

  aging_thread_scheduler_core #(.THREAD_SLOTS(SLOTS)) u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .quantum_limit  (quantum_limit),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .target_thread  (target_thread),
    .owner_id       (owner_id),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .running_thread (running_thread),
    .switched       (switched),
    .status         (status),
    .created_thread (created_thread)
  );

  always #5 clk = ~clk;

  logic [2:0]  slot_state [SLOTS];
  logic [15:0] slot_age   [SLOTS];
  logic [7:0]  slot_owner [SLOTS];
  logic [3:0]  run_idx;
  logic [15:0] quantum_cnt;
  logic [15:0] limit_val;
  bit   [15:0] age_known;

  sched_cmd_t  cmd_q [$];
  ats_result_t sched_result_q [$];

  bit          quiet = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          cycle_cnt = 0;
  int          n_err = 0;
  int          n_checked = 0;
  int          n_passes = 0;
  int          n_no_slot = 0;
  int          n_cfg = 0;
  sched_cmd_t  drv_item;
  ats_result_t want;
  ats_result_t seen;

  function automatic void select_pass();
    int          pick;
    logic [15:0] old;
    bit          win;
    pick = 0;
    if (slot_state[run_idx] == ST_RUNNING) slot_state[run_idx] = ST_READY;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_state[i] == ST_READY) begin
        old = slot_age[i];
        if (old != AGE_MAX) slot_age[i] = old + 16'd1;
        win = (i == pick) || (old >= slot_age[pick]);
        if (win) pick = i;
      end
    end
    run_idx = pick[3:0];
    slot_age[pick] = 16'd0;
    quantum_cnt = 16'd0;
    slot_state[pick] = ST_RUNNING;
  endfunction

  function automatic ats_result_t schedule_step(input sched_cmd_t c);
    ats_result_t r;
    logic [15:0] old;
    bit          found;
    r = '0;
    r.status = STS_OK;
    found = 1'b0;
    case (c.cmd)
      CMD_TICK: begin
        old = quantum_cnt;
        if (old != AGE_MAX) quantum_cnt = old + 16'd1;
        if (old >= limit_val) begin
          select_pass();
          r.switched = 1'b1;
        end
      end
      CMD_YIELD: begin
        select_pass();
        r.switched = 1'b1;
      end
      CMD_SLEEP: begin
        slot_state[run_idx] = ST_WAITING;
        select_pass();
        r.switched = 1'b1;
      end
      CMD_WAKEUP: begin
        if (c.tid == KERNEL_IDX) r.status = STS_BAD_INDEX;
        else slot_state[c.tid] = ST_READY;
      end
      CMD_CREATE: begin
        r.status = STS_NO_SLOT;
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && slot_state[i] == ST_AVAILABLE) begin
            slot_state[i] = ST_READY;
            slot_age[i] = 16'd1;
            slot_owner[i] = c.owner;
            r.created_thread = i[3:0];
            r.status = STS_OK;
            found = 1'b1;
          end
        end
      end
      CMD_FREE: begin
        if (c.tid == KERNEL_IDX) begin
          r.status = STS_BAD_INDEX;
        end else begin
          slot_state[c.tid] = ST_AVAILABLE;
          slot_age[c.tid] = AGE_MAX;
          slot_owner[c.tid] = FREE_OWNER;
        end
      end
      default: ;
    endcase
    r.running_thread = run_idx;
    return r;
  endfunction

  task automatic push_cmd(input logic [2:0] c, input logic [3:0] t, input logic [7:0] o);
    sched_cmd_t item;
    item.cmd = c;
    item.tid = t;
    item.owner = o;
    if (c == CMD_FREE && t != KERNEL_IDX) age_known[t] = 1'b1;
    cmd_q.push_back(item);
  endtask

  task automatic drain();
    @(negedge clk);
    while (cmd_q.size() != 0 || in_valid || sched_result_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] lim, input int mode, input int n);
    logic [2:0] cmd;
    logic [3:0] tid;
    logic [7:0] own;
    int         r;
    cfg_valid <= 1'b1;
    quantum_limit <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_val = lim;
    n_cfg++;
    cfg_valid <= 1'b0;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (mode == MODE_TICKS && $urandom_range(0, 1) == 1) r = 0;
      if (mode == MODE_CREATES && $urandom_range(0, 1) == 1) r = 70;
      tid = 4'($urandom_range(0, 15));
      own = 8'($urandom_range(0, 255));
      if (r < 25) begin
        cmd = CMD_TICK;
      end else if (r < 38) begin
        cmd = CMD_YIELD;
      end else if (r < 46) begin
        cmd = CMD_SLEEP;
      end else if (r < 62) begin
        cmd = CMD_WAKEUP;
        if ($urandom_range(0, 9) == 0) begin
          tid = KERNEL_IDX;
        end else begin
          tid = 4'($urandom_range(1, 15));
          // free an untouched slot first so its age is defined
          if (!age_known[tid]) cmd = CMD_FREE;
        end
      end else if (r < 78) begin
        cmd = CMD_CREATE;
      end else if (r < 95) begin
        cmd = CMD_FREE;
      end else begin
        cmd = ($urandom_range(0, 1) == 1) ? CMD_SPARE_B : CMD_SPARE_A;
      end
      push_cmd(cmd, tid, own);
    end
    drain();
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        drv_item.cmd = command;
        drv_item.tid = target_thread;
        drv_item.owner = owner_id;
        sched_result_q.push_back(schedule_step(drv_item));
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(0, 8);
          in_valid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          drv_item = cmd_q.pop_front();
          command <= drv_item.cmd;
          target_thread <= drv_item.tid;
          owner_id <= drv_item.owner;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen.running_thread = running_thread;
        seen.switched = switched;
        seen.status = status;
        seen.created_thread = created_thread;
        if (sched_result_q.size() == 0) begin
          $error("unexpected result item: running_thread %0d", seen.running_thread);
          n_err++;
        end else begin
          want = sched_result_q.pop_front();
          n_checked++;
          if (want.switched) n_passes++;
          if (want.status == STS_NO_SLOT) n_no_slot++;
          if (seen.running_thread !== want.running_thread) begin
            $error("running_thread: expected %0d, actual %0d",
                   want.running_thread, seen.running_thread);
            n_err++;
          end
          if (seen.switched !== want.switched) begin
            $error("switched: expected %0d, actual %0d", want.switched, seen.switched);
            n_err++;
          end
          if (seen.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, seen.status);
            n_err++;
          end
          if (seen.created_thread !== want.created_thread) begin
            $error("created_thread: expected %0d, actual %0d",
                   want.created_thread, seen.created_thread);
            n_err++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_state[i] = ST_AVAILABLE;
      slot_age[i] = 16'd0;
      slot_owner[i] = FREE_OWNER;
    end
    slot_state[KERNEL_IDX] = ST_RUNNING;
    slot_age[KERNEL_IDX] = 16'd1;
    slot_owner[KERNEL_IDX] = KERNEL_OWNER;
    run_idx = KERNEL_IDX;
    quantum_cnt = 16'd0;
    limit_val = QUANTUM_RESET;
    age_known = 16'h0001;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    push_cmd(CMD_SPARE_A, 4'd0, 8'h00);
    push_cmd(CMD_SPARE_B, 4'd15, 8'hFF);
    push_cmd(CMD_TICK, 4'd15, 8'hFF);
    // kernel thread alone, then asleep with nothing ready
    push_cmd(CMD_YIELD, 4'd0, 8'h00);
    push_cmd(CMD_SLEEP, 4'd0, 8'h00);
    push_cmd(CMD_WAKEUP, KERNEL_IDX, 8'h00);
    push_cmd(CMD_FREE, KERNEL_IDX, 8'h00);
    // freed slot woken with saturated age
    push_cmd(CMD_FREE, 4'd15, 8'h00);
    push_cmd(CMD_WAKEUP, 4'd15, 8'h00);
    push_cmd(CMD_YIELD, 4'd0, 8'h00);
    push_cmd(CMD_CREATE, 4'd0, 8'hAA);
    push_cmd(CMD_CREATE, 4'd0, 8'h55);
    push_cmd(CMD_YIELD, 4'd0, 8'h00);
    push_cmd(CMD_YIELD, 4'd0, 8'h00);
    push_cmd(CMD_WAKEUP, 4'd1, 8'h00);
    push_cmd(CMD_SLEEP, 4'd0, 8'h00);
    push_cmd(CMD_WAKEUP, 4'd2, 8'h00);
    push_cmd(CMD_FREE, 4'd1, 8'h00);
    push_cmd(CMD_TICK, 4'd0, 8'h00);
    push_cmd(CMD_YIELD, 4'd0, 8'h00);
    push_cmd(CMD_FREE, 4'd2, 8'h00);
    push_cmd(CMD_YIELD, 4'd0, 8'h00);
    drain();

    run_phase(16'd0, MODE_TICKS, 50);
    run_phase(16'hFFFF, MODE_MIXED, 50);
    run_phase(16'd1, MODE_CREATES, 50);
    run_phase(16'd4, MODE_TICKS, 50);
    run_phase(16'($urandom_range(2, 30)), MODE_MIXED, 50);
    run_phase(QUANTUM_RESET, MODE_CREATES, 50);
    run_phase(16'($urandom_range(0, 65535)), MODE_MIXED, 50);
    quiet = 1'b1;
    run_phase(16'd2, MODE_TICKS, 50);

    $display("Checked %0d result items across %0d quantum limit settings", n_checked, n_cfg);
    $display("Saw %0d selection passes and %0d creates refused for a full table",
             n_passes, n_no_slot);
    if (n_err == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
